// ===== rtl/uer_pkg.sv =====
package uer_pkg;

  localparam int COUNT_WIDTH_DEF = 12;
  localparam int SCALE_Q16_DEF   = 11239;

  localparam int THRESH_W   = 8;
  localparam int TIMEOUT_W  = 12;
  localparam int DIST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [THRESH_W-1:0]  THRESH_RST   = 8'd30;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST  = 12'd200;
  localparam logic [DIST_W-1:0]    TIMEOUT_DIST = 8'd127;
  localparam logic [DIST_W-1:0]    DIST_MAX     = 8'd255;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 2'd1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_COUNT = 3'b100
  } phase_t;

endpackage

// ===== rtl/uer_if.sv =====
interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink (input valid, input start_req, input echo, output ready);
endinterface

interface uer_out_if import uer_pkg::*;;
  logic              valid;
  logic              ready;
  logic              trigger;
  logic              done_res;
  logic [DIST_W-1:0] distance_cm;
  logic              near;
  logic              timed_out;

  modport source (output valid, output trigger, output done_res, output distance_cm,
                  output near, output timed_out, input ready);
  modport sink (input valid, input trigger, input done_res, input distance_cm,
                input near, input timed_out, output ready);
endinterface

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger. Each input transaction is one 10 us tick carrying a start
// request and the sampled echo level, and each one yields exactly one registered
// result transaction: the trigger level for that tick, and on the tick a measurement
// ends, the distance in cm (echo-high ticks times 0.1715, rounded and saturated to
// 255, or 127 after a timeout), the near flag and the timeout flag.
// The block takes one tick per clock cycle; its single output register is freed
// in the same cycle its result is taken, so input is stalled only while a result
// waits unread. The user must write registers through the cfg port only while no tick
// is in flight; the block itself does not enforce this.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int SCALE_Q16   = SCALE_Q16_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  uer_in_if.sink                in_ch,
  uer_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CntW  = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;
  localparam int ProdW = CntW + 16;
  localparam logic [CntW-1:0]  CntMax = CntW'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [ProdW-1:0] Scale  = ProdW'(SCALE_Q16);
  localparam logic [ProdW-1:0] Half   = ProdW'(32768);

  logic [THRESH_W-1:0]  thresh_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  phase_t               phase_r, phase_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;

  logic                 out_valid_r;
  logic                 trigger_r, trigger_nxt;
  logic                 done_r, done_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic                 near_r, near_nxt;
  logic                 tmo_r, tmo_nxt;

  logic                 accept;
  logic [CntW:0]        wait_inc;
  logic [CntW:0]        limit;
  logic [ProdW-1:0]     prod;
  logic [CntW-1:0]      quot;
  logic [DIST_W-1:0]    dist_calc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign wait_inc  = {1'b0, cnt_r} + {{CntW{1'b0}}, 1'b1};
  assign limit     = (timeout_r == '0) ? {{CntW{1'b0}}, 1'b1}
                                       : (CntW + 1)'(timeout_r);
  assign prod      = ProdW'(cnt_r) * Scale + Half;
  assign quot      = prod[ProdW-1:16];
  assign dist_calc = (quot > CntW'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];

  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    trigger_nxt = 1'b0;
    done_nxt    = 1'b0;
    dist_nxt    = '0;
    tmo_nxt     = 1'b0;
    case (phase_r)
      PH_WAIT: begin
        if (in_ch.echo) begin
          phase_nxt = PH_COUNT;
          cnt_nxt   = {{(CntW-1){1'b0}}, 1'b1};
        end else if (wait_inc >= limit) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          done_nxt  = 1'b1;
          tmo_nxt   = 1'b1;
          dist_nxt  = TIMEOUT_DIST;
        end else begin
          cnt_nxt = wait_inc[CntW-1:0];
        end
      end
      PH_COUNT: begin
        if (in_ch.echo) begin
          if (cnt_r < CntMax) begin
            cnt_nxt = wait_inc[CntW-1:0];
          end
        end else begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          done_nxt  = 1'b1;
          dist_nxt  = dist_calc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (in_ch.start_req) begin
          phase_nxt   = PH_WAIT;
          cnt_nxt     = '0;
          trigger_nxt = 1'b1;
        end
      end
    endcase
    near_nxt = done_nxt && (dist_nxt != '0) && (dist_nxt <= thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESH_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IDX_THRESHOLD: thresh_r  <= cfg_wdata[THRESH_W-1:0];
        CFG_IDX_TIMEOUT:   timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_r <= trigger_nxt;
      done_r    <= done_nxt;
      dist_r    <= dist_nxt;
      near_r    <= near_nxt;
      tmo_r     <= tmo_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.trigger     = trigger_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.distance_cm = dist_r;
  assign out_ch.near        = near_r;
  assign out_ch.timed_out   = tmo_r;

endmodule

// ===== rtl/uer_checker.sv =====
module uer_checker import uer_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              trigger,
  input logic              done_res,
  input logic [DIST_W-1:0] distance_cm,
  input logic              near,
  input logic              timed_out
);

  // A result that waits unread must not change.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm) && $stable(done_res)
      && $stable(trigger))
    else $error("stalled result changed");

  // A waiting result holds back the next input transaction.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over an unread result");

  // Measurement fields are zero on ticks that do not finish a measurement.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> distance_cm == '0 && !near && !timed_out)
    else $error("measurement fields set without done");

  // A timeout always reports the fixed timeout distance.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && timed_out |-> done_res && distance_cm == TIMEOUT_DIST)
    else $error("timeout result malformed");

  // The trigger tick can never also finish a measurement.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && trigger |-> !done_res)
    else $error("trigger and done on the same tick");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .trigger     (out_ch.trigger),
  .done_res    (out_ch.done_res),
  .distance_cm (out_ch.distance_cm),
  .near        (out_ch.near),
  .timed_out   (out_ch.timed_out)
);

// ===== sim/ultrasonic_echo_ranger_tb.sv =====
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic              trigger;
    logic              done_res;
    logic [DIST_W-1:0] distance_cm;
    logic              near;
    logic              timed_out;
  } range_result_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  uer_in_if  in_ch ();
  uer_out_if out_ch ();

  ultrasonic_echo_ranger i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  phase_t                     ranger_phase;
  logic [COUNT_WIDTH_DEF-1:0] ranger_ticks;
  logic [THRESH_W-1:0]        near_limit_cm;
  logic [TIMEOUT_W-1:0]       echo_timeout;

  range_result_t expected_results[$];
  int unsigned   mismatches;
  int unsigned   ticks_sent;
  int unsigned   snd_idle_pct;
  int unsigned   rcv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ultrasonic_echo_ranger test failed");
    $finish;
  end

  function automatic logic [DIST_W-1:0] ticks_to_cm(input logic [COUNT_WIDTH_DEF-1:0] n);
    logic [31:0] scaled;
    scaled = (32'(n) * 32'(SCALE_Q16_DEF) + 32'd32768) >> 16;
    return (scaled > 32'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
  endfunction

  task automatic predict_tick(input bit start, input bit echo_lvl);
    range_result_t        r;
    logic [TIMEOUT_W-1:0] limit;
    r = '0;
    case (ranger_phase)
      PH_WAIT: begin
        if (echo_lvl) begin
          ranger_phase = PH_COUNT;
          ranger_ticks = COUNT_WIDTH_DEF'(1);
        end else begin
          limit = (echo_timeout == '0) ? TIMEOUT_W'(1) : echo_timeout;
          ranger_ticks++;
          if (ranger_ticks >= limit) begin
            r.done_res = 1'b1;
            r.timed_out = 1'b1;
            r.distance_cm = TIMEOUT_DIST;
            ranger_phase = PH_IDLE;
            ranger_ticks = '0;
          end
        end
      end
      PH_COUNT: begin
        if (echo_lvl) begin
          if (ranger_ticks != '1) ranger_ticks++;
        end else begin
          r.done_res = 1'b1;
          r.distance_cm = ticks_to_cm(ranger_ticks);
          ranger_phase = PH_IDLE;
          ranger_ticks = '0;
        end
      end
      default: begin
        ranger_phase = PH_IDLE;
        if (start) begin
          r.trigger = 1'b1;
          ranger_phase = PH_WAIT;
          ranger_ticks = '0;
        end
      end
    endcase
    if (r.done_res && r.distance_cm != '0 && r.distance_cm <= near_limit_cm) r.near = 1'b1;
    expected_results.push_back(r);
  endtask

  task automatic send_tick(input bit start, input bit echo_lvl);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_req <= start;
    in_ch.echo <= echo_lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_tick(start, echo_lvl);
    ticks_sent++;
  endtask

  // One ranging cycle: trigger, echo-low wait, echo-high pulse, falling edge.
  task automatic run_measurement(input int unsigned wait_len, input int unsigned high_len,
                                 input bit noisy);
    send_tick(1'b1, noisy ? 1'($urandom_range(0, 1)) : 1'b0);
    repeat (wait_len) send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, 1'b0);
    repeat (high_len) send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, 1'b1);
    send_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, 1'b0);
  endtask

  task automatic settle();
    while (ranger_phase != PH_IDLE) send_tick(1'b0, 1'b0);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_IDX_THRESHOLD: near_limit_cm = data[THRESH_W-1:0];
      CFG_IDX_TIMEOUT:   echo_timeout = data[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int unsigned thresh, input int unsigned tmo);
    write_reg(CFG_IDX_THRESHOLD, CFG_DATA_W'(thresh));
    write_reg(CFG_IDX_TIMEOUT, CFG_DATA_W'(tmo));
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [DIST_W-1:0] want,
                             input logic [DIST_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin
    range_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no tick outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("trigger", DIST_W'(want.trigger), DIST_W'(out_ch.trigger));
        check_field("done_res", DIST_W'(want.done_res), DIST_W'(out_ch.done_res));
        check_field("distance_cm", want.distance_cm, out_ch.distance_cm);
        check_field("near", DIST_W'(want.near), DIST_W'(out_ch.near));
        check_field("timed_out", DIST_W'(want.timed_out), DIST_W'(out_ch.timed_out));
      end
    end
  end

  task automatic test_reset_defaults();
    run_measurement(2, 175, 1'b0);
    run_measurement(0, 182, 1'b0);
    run_measurement(210, 0, 1'b0);
    settle();
  endtask

  task automatic test_special_cases();
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    settle();
    set_config(30, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    settle();
    set_config(3, 5);
    write_reg(CFG_IDX_SPARE_A, '1);
    write_reg(CFG_IDX_SPARE_B, '0);
    cfg_we <= 1'b0;
    run_measurement(3, 21, 1'b0);
    run_measurement(6, 0, 1'b0);
    settle();
  endtask

  task automatic test_threshold_extremes();
    set_config(0, 4);
    run_measurement(0, 3, 1'b0);
    run_measurement(6, 0, 1'b0);
    settle();
    set_config(127, 4);
    run_measurement(6, 0, 1'b0);
    settle();
    set_config(126, 4);
    run_measurement(6, 0, 1'b0);
    settle();
    set_config(255, 4);
    run_measurement(6, 0, 1'b0);
    run_measurement(0, 40, 1'b0);
    settle();
  endtask

  // Mostly well-formed ranging cycles with random timing, mixed with bursts of noise.
  task automatic test_random_ranging(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned wait_len;
    int unsigned high_len;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        wait_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, int'(echo_timeout) + 2)
                                               : $urandom_range(0, 4);
        high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
        run_measurement(wait_len, high_len, 1'b1);
      end
    end
    settle();
  endtask

  initial begin
    mismatches = 0;
    ticks_sent = 0;
    snd_idle_pct = 15;
    rcv_idle_pct = 86;
    ranger_phase = PH_IDLE;
    ranger_ticks = '0;
    near_limit_cm = THRESH_RST;
    echo_timeout = TIMEOUT_RST;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.start_req <= 1'b0;
    in_ch.echo <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_IDX_THRESHOLD;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_special_cases();
    test_threshold_extremes();

    set_config($urandom_range(0, 40), $urandom_range(1, 16));
    test_random_ranging(120);

    snd_idle_pct = 86;
    rcv_idle_pct = 15;
    set_config($urandom_range(0, 255), 1);
    test_random_ranging(120);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_config(255, $urandom_range(2, 30));
    test_random_ranging(120);

    if (expected_results.size() != 0) begin
      $error("%0d result transactions never arrived", expected_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ultrasonic_echo_ranger test passed");
    end else begin
      $display("ultrasonic_echo_ranger test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/uer_pkg.sv
rtl/uer_if.sv
rtl/ultrasonic_echo_ranger.sv
rtl/uer_checker.sv
sim/ultrasonic_echo_ranger_tb.sv
